### rtl/core/sqve_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sqve_pkg;

   // Field widths
   localparam int unsigned PosW  = 32;
   localparam int unsigned OfsW  = 48;  // corner offset, floor of a 65-bit value by 2^17
   localparam int unsigned TrigW = 18;  // signed Q1.14 sine and cosine with headroom
   localparam int unsigned AngW  = 15;  // wrapped angle, 0 .. 23039
   localparam int unsigned RemW  = 13;  // angle within a quadrant, 0 .. 5759

   // Angle constants, Q10.6 degrees
   localparam int unsigned FullTurn    = 23040;
   localparam int unsigned QuarterTurn = 5760;
   localparam int unsigned RadPerStep  = 292818;  // radians per angle step, Q2.30

   localparam logic [30:0] Q30One = 31'h4000_0000;

   // Exact reciprocals for 32-bit numerators: ceil(2^(32+l) / d), 2^(l-1) < d <= 2^l
   localparam int unsigned Sh72 = 39;
   localparam int unsigned Sh42 = 38;
   localparam int unsigned Sh20 = 37;
   localparam int unsigned Sh6  = 35;
   localparam int unsigned Sh90 = 39;
   localparam int unsigned Sh56 = 38;
   localparam int unsigned Sh30 = 37;
   localparam int unsigned Sh12 = 36;
   localparam logic [63:0] RecipFull72 = ((64'd1 << Sh72) + 64'd71) / 64'd72;
   localparam logic [63:0] RecipFull42 = ((64'd1 << Sh42) + 64'd41) / 64'd42;
   localparam logic [63:0] RecipFull20 = ((64'd1 << Sh20) + 64'd19) / 64'd20;
   localparam logic [63:0] RecipFull6  = ((64'd1 << Sh6) + 64'd5) / 64'd6;
   localparam logic [63:0] RecipFull90 = ((64'd1 << Sh90) + 64'd89) / 64'd90;
   localparam logic [63:0] RecipFull56 = ((64'd1 << Sh56) + 64'd55) / 64'd56;
   localparam logic [63:0] RecipFull30 = ((64'd1 << Sh30) + 64'd29) / 64'd30;
   localparam logic [63:0] RecipFull12 = ((64'd1 << Sh12) + 64'd11) / 64'd12;

   typedef struct packed {
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic signed [31:0] center_z;
      logic signed [31:0] scale_x;
      logic signed [31:0] scale_y;
      logic signed [31:0] quad_width;
      logic signed [31:0] quad_height;
      logic signed [15:0] rotation_deg;
      logic [63:0]        color_rgba;
      logic [63:0]        uv_corners_ab;
      logic [63:0]        uv_corners_cd;
      logic [4:0]         texture_slot;
   } req_type;

   typedef struct packed {
      logic signed [31:0] vertex_x;
      logic signed [31:0] vertex_y;
      logic signed [31:0] vertex_z;
      logic [63:0]        vertex_color;
      logic [15:0]        vertex_u;
      logic [15:0]        vertex_v;
      logic [4:0]         vertex_slot;
      logic [1:0]         corner_index;
      logic               last_vertex;
   } rsp_type;

   // Sprite fields carried down the pipeline untouched
   typedef struct packed {
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic signed [31:0] center_z;
      logic [63:0]        color_rgba;
      logic [63:0]        uv_corners_ab;
      logic [63:0]        uv_corners_cd;
      logic [4:0]         texture_slot;
      logic               rotated;
   } pass_type;

   typedef struct packed {
      logic signed [OfsW-1:0] ox_pos;
      logic signed [OfsW-1:0] ox_neg;
      logic signed [OfsW-1:0] oy_pos;
      logic signed [OfsW-1:0] oy_neg;
   } ofs_type;

   // Per-vertex fields travelling beside the rotation arithmetic
   typedef struct packed {
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic signed [31:0] vertex_z;
      logic [63:0]        vertex_color;
      logic [15:0]        vertex_u;
      logic [15:0]        vertex_v;
      logic [4:0]         vertex_slot;
      logic [1:0]         corner_index;
      logic               last_vertex;
   } vmeta_type;

endpackage

`default_nettype wire

### rtl/core/sqve_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sqve_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### rtl/core/sprite_quad_vertex_expander.sv
// Requests flow through the sprite pipeline, expander, vertex pipeline and response register.
// Throughput: four vertices per sprite at one per cycle unless the response channel stalls;
// the corner counter in front of the single response register sets that rate.
// The 14-stage sprite pipeline takes a new sprite in every cycle while it has room.
// Reset clears every valid bit and the corner counter; data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module sprite_quad_vertex_expander
   import sqve_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   sqve_stream_if.sink   req_chan,
   sqve_stream_if.source rsp_chan
);

   localparam int unsigned SLast = 14;

   // Reciprocal divide of a 32-bit value; quotient always below 2^30 here
   function automatic logic [29:0] recip_div(input logic [31:0] v, input logic [63:0] m,
                                             input int unsigned sh);
      logic [64:0] p;
      p = 65'(v) * 65'(m[32:0]);
      p = p >> sh;
      return p[29:0];
   endfunction

   // One Horner step: (x2 * (1 - q)) >> 30
   function automatic logic [31:0] horner_mul(input logic [31:0] x2, input logic [29:0] q);
      logic [30:0] t;
      logic [62:0] p;
      t = Q30One - 31'(q);
      p = 63'(x2) * 63'(t);
      return p[61:30];
   endfunction

   // Handshake control
   logic            sen;
   logic            ven;
   logic            exp_take;
   logic [SLast:1]  s_vld_ff;
   logic            exp_vld_ff;
   logic [1:0]      exp_cnt_ff;
   logic            v1_vld_ff, v2_vld_ff, v3_vld_ff, rsp_vld_ff;

   // Sprite pipeline registers
   req_type                 in_ff;
   pass_type                pass_in;
   pass_type                pass_ff [2:SLast];
   logic signed [63:0]      px_ff, py_ff, px_in, py_in;
   logic [AngW-1:0]         ang_ff, ang_in;
   ofs_type                 ofs_in;
   ofs_type                 ofs_ff [3:SLast];
   logic [1:0]              quad_in;
   logic [1:0]              quad_ff [3:SLast-1];
   logic [RemW-1:0]         rem_ff, rem_in;
   logic [30:0]             x_in;
   logic [30:0]             x_ff [4:12];
   logic [31:0]             x2_in;
   logic [31:0]             x2_ff [5:12];
   logic [29:0]             s_q6_ff, s_q8_ff, s_q10_ff, s_q12_ff;
   logic [29:0]             c_q6_ff, c_q8_ff, c_q10_ff, c_q12_ff;
   logic [31:0]             s_m7_ff, s_m9_ff, s_m11_ff;
   logic [31:0]             c_m7_ff, c_m9_ff, c_m11_ff;
   logic [31:0]             s30_ff, s30_in;
   logic [30:0]             hc_ff, hc_in;
   logic signed [TrigW-1:0] sn_ff, cs_ff, sn_in, cs_in;

   // Expander and vertex pipeline registers
   pass_type                exp_pass_ff;
   ofs_type                 exp_ofs_ff;
   logic signed [TrigW-1:0] exp_sn_ff, exp_cs_ff;
   vmeta_type               v1_meta_in, v1_meta_ff, v2_meta_ff, v3_meta_ff;
   logic signed [OfsW-1:0]  v1_ox_in, v1_oy_in, v1_ox_ff, v1_oy_ff;
   logic signed [TrigW-1:0] v1_sn_ff, v1_cs_ff;
   logic signed [OfsW+TrigW-1:0] p_cx_ff, p_sy_ff, p_sx_ff, p_cy_ff;
   logic signed [OfsW+TrigW-1:0] p_cx_in, p_sy_in, p_sx_in, p_cy_in;
   logic signed [52:0]      rx_ff, ry_ff, rx_in, ry_in;
   rsp_type                 rsp_ff, rsp_in;

   // Stall control: the expander paces everything upstream
   assign ven      = !rsp_vld_ff || rsp_chan.ready;
   assign exp_take = !exp_vld_ff || (ven && (exp_cnt_ff == 2'd3));
   assign sen      = !s_vld_ff[SLast] || exp_take;
   assign req_chan.ready = sen;

   // Stage 2: size products, angle wrap
   always_comb begin
      logic signed [16:0] ra;
      ra = {in_ff.rotation_deg[15], in_ff.rotation_deg};
      px_in = $signed(in_ff.scale_x) * $signed(in_ff.quad_width);
      py_in = $signed(in_ff.scale_y) * $signed(in_ff.quad_height);
      if (ra < -17'sd23040) begin
         ang_in = AngW'(ra + 17'sd46080);
      end else if (ra < 17'sd0) begin
         ang_in = AngW'(ra + 17'sd23040);
      end else if (ra >= 17'sd23040) begin
         ang_in = AngW'(ra - 17'sd23040);
      end else begin
         ang_in = AngW'(ra);
      end
      pass_in.center_x      = in_ff.center_x;
      pass_in.center_y      = in_ff.center_y;
      pass_in.center_z      = in_ff.center_z;
      pass_in.color_rgba    = in_ff.color_rgba;
      pass_in.uv_corners_ab = in_ff.uv_corners_ab;
      pass_in.uv_corners_cd = in_ff.uv_corners_cd;
      pass_in.texture_slot  = in_ff.texture_slot;
      pass_in.rotated       = (in_ff.rotation_deg != 16'sd0);
   end

   // Stage 3: corner offsets with round-half-up, quadrant split
   always_comb begin
      logic signed [64:0] pxe, pye, sxp, sxn, syp, syn;
      pxe = {px_ff[63], px_ff};
      pye = {py_ff[63], py_ff};
      sxp = pxe + 65'sd65536;
      sxn = -pxe + 65'sd65536;
      syp = pye + 65'sd65536;
      syn = -pye + 65'sd65536;
      ofs_in.ox_pos = sxp[64:17];
      ofs_in.ox_neg = sxn[64:17];
      ofs_in.oy_pos = syp[64:17];
      ofs_in.oy_neg = syn[64:17];
      if (ang_ff >= AngW'(3 * QuarterTurn)) begin
         quad_in = 2'd3;
         rem_in  = RemW'(ang_ff - AngW'(3 * QuarterTurn));
      end else if (ang_ff >= AngW'(2 * QuarterTurn)) begin
         quad_in = 2'd2;
         rem_in  = RemW'(ang_ff - AngW'(2 * QuarterTurn));
      end else if (ang_ff >= AngW'(QuarterTurn)) begin
         quad_in = 2'd1;
         rem_in  = RemW'(ang_ff - AngW'(QuarterTurn));
      end else begin
         quad_in = 2'd0;
         rem_in  = RemW'(ang_ff);
      end
   end

   // Stages 4 and 5: angle in radians and its square
   always_comb begin
      logic [31:0] xp;
      logic [61:0] x2p;
      xp    = 32'(rem_ff) * 32'(RadPerStep);
      x_in  = xp[30:0];
      x2p   = 62'(x_ff[4]) * 62'(x_ff[4]);
      x2_in = x2p[61:30];
   end

   // Stages 13 and 14: final terms, rounding and quadrant mapping; unrotated sprites get sine 0, cosine 1
   always_comb begin
      logic [61:0]  sp;
      logic [62:0]  cp;
      logic [30:0]  c30;
      logic [32:0]  sr;
      logic [31:0]  cr;
      logic signed [TrigW-1:0] sv, cv;
      sp     = 62'(x_ff[12]) * 62'(Q30One - 31'(s_q12_ff));
      s30_in = sp[61:30];
      cp     = 63'(x2_ff[12]) * 63'(Q30One - 31'(c_q12_ff));
      hc_in  = cp[61:31];
      c30    = (hc_ff >= Q30One) ? 31'd0 : (Q30One - hc_ff);
      sr     = 33'(s30_ff) + 33'd32768;
      cr     = 32'(c30) + 32'd32768;
      sv     = $signed({1'b0, sr[32:16]});
      cv     = $signed({2'b0, cr[31:16]});
      case (quad_ff[13])
         2'd0: begin sn_in = sv;  cs_in = cv;  end
         2'd1: begin sn_in = cv;  cs_in = -sv; end
         2'd2: begin sn_in = -sv; cs_in = -cv; end
         default: begin sn_in = -cv; cs_in = sv; end
      endcase
      if (!pass_ff[13].rotated) begin
         sn_in = '0;
         cs_in = TrigW'(18'sd16384);
      end
   end

   // Advance the sprite pipeline data
   always_ff @(posedge clock) begin
      if (sen) begin
         in_ff          <= req_chan.payload;
         pass_ff[2]     <= pass_in;
         px_ff          <= px_in;
         py_ff          <= py_in;
         ang_ff         <= ang_in;
         ofs_ff[3]      <= ofs_in;
         quad_ff[3]     <= quad_in;
         rem_ff         <= rem_in;
         x_ff[4]        <= x_in;
         x2_ff[5]       <= x2_in;
         for (int i = 3; i <= SLast; i++) begin
            pass_ff[i] <= pass_ff[i-1];
         end
         for (int i = 4; i <= SLast; i++) begin
            ofs_ff[i]  <= ofs_ff[i-1];
         end
         for (int i = 4; i <= SLast - 1; i++) begin
            quad_ff[i] <= quad_ff[i-1];
         end
         for (int i = 5; i <= 12; i++) begin
            x_ff[i] <= x_ff[i-1];
         end
         for (int i = 6; i <= 12; i++) begin
            x2_ff[i] <= x2_ff[i-1];
         end
         s_q6_ff  <= recip_div(x2_ff[5], RecipFull72, Sh72);
         c_q6_ff  <= recip_div(x2_ff[5], RecipFull90, Sh90);
         s_m7_ff  <= horner_mul(x2_ff[6], s_q6_ff);
         c_m7_ff  <= horner_mul(x2_ff[6], c_q6_ff);
         s_q8_ff  <= recip_div(s_m7_ff, RecipFull42, Sh42);
         c_q8_ff  <= recip_div(c_m7_ff, RecipFull56, Sh56);
         s_m9_ff  <= horner_mul(x2_ff[8], s_q8_ff);
         c_m9_ff  <= horner_mul(x2_ff[8], c_q8_ff);
         s_q10_ff <= recip_div(s_m9_ff, RecipFull20, Sh20);
         c_q10_ff <= recip_div(c_m9_ff, RecipFull30, Sh30);
         s_m11_ff <= horner_mul(x2_ff[10], s_q10_ff);
         c_m11_ff <= horner_mul(x2_ff[10], c_q10_ff);
         s_q12_ff <= recip_div(s_m11_ff, RecipFull6, Sh6);
         c_q12_ff <= recip_div(c_m11_ff, RecipFull12, Sh12);
         s30_ff   <= s30_in;
         hc_ff    <= hc_in;
         sn_ff    <= sn_in;
         cs_ff    <= cs_in;
      end
   end

   // Shift the sprite valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s_vld_ff <= '0;
      end else if (sen) begin
         s_vld_ff <= {s_vld_ff[SLast-1:1], req_chan.valid};
      end
   end

   // Hold a sprite while its four corners go out
   always_ff @(posedge clock) begin
      if (exp_take) begin
         exp_pass_ff <= pass_ff[SLast];
         exp_ofs_ff  <= ofs_ff[SLast];
         exp_sn_ff   <= sn_ff;
         exp_cs_ff   <= cs_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_vld_ff <= 1'b0;
         exp_cnt_ff <= 2'd0;
      end else if (exp_take) begin
         exp_vld_ff <= s_vld_ff[SLast];
         exp_cnt_ff <= 2'd0;
      end else if (ven) begin
         exp_cnt_ff <= exp_cnt_ff + 2'd1;
      end
   end

   // Select the corner offsets and uv
   always_comb begin
      logic [63:0] word;
      word = exp_cnt_ff[1] ? exp_pass_ff.uv_corners_cd : exp_pass_ff.uv_corners_ab;
      v1_ox_in = exp_cnt_ff[1] ? exp_ofs_ff.ox_neg : exp_ofs_ff.ox_pos;
      v1_oy_in = (exp_cnt_ff[1] ^ exp_cnt_ff[0]) ? exp_ofs_ff.oy_pos : exp_ofs_ff.oy_neg;
      v1_meta_in.center_x     = exp_pass_ff.center_x;
      v1_meta_in.center_y     = exp_pass_ff.center_y;
      v1_meta_in.vertex_z     = exp_pass_ff.rotated ? exp_pass_ff.center_z : 32'sd0;
      v1_meta_in.vertex_color = exp_pass_ff.color_rgba;
      v1_meta_in.vertex_u     = exp_cnt_ff[0] ? word[31:16] : word[63:48];
      v1_meta_in.vertex_v     = exp_cnt_ff[0] ? word[15:0] : word[47:32];
      v1_meta_in.vertex_slot  = exp_pass_ff.texture_slot;
      v1_meta_in.corner_index = exp_cnt_ff;
      v1_meta_in.last_vertex  = (exp_cnt_ff == 2'd3);
   end

   // Rotation products, sums with rounding, translation and saturation
   always_comb begin
      logic signed [OfsW+TrigW:0] sx, sy;
      logic signed [53:0]         fx, fy;
      p_cx_in = v1_cs_ff * v1_ox_ff;
      p_sy_in = v1_sn_ff * v1_oy_ff;
      p_sx_in = v1_sn_ff * v1_ox_ff;
      p_cy_in = v1_cs_ff * v1_oy_ff;
      sx = {p_cx_ff[OfsW+TrigW-1], p_cx_ff} - {p_sy_ff[OfsW+TrigW-1], p_sy_ff}
           + 67'sd8192;
      sy = {p_sx_ff[OfsW+TrigW-1], p_sx_ff} + {p_cy_ff[OfsW+TrigW-1], p_cy_ff}
           + 67'sd8192;
      rx_in = sx[66:14];
      ry_in = sy[66:14];
      fx = {rx_ff[52], rx_ff} + {{22{v3_meta_ff.center_x[31]}}, v3_meta_ff.center_x};
      fy = {ry_ff[52], ry_ff} + {{22{v3_meta_ff.center_y[31]}}, v3_meta_ff.center_y};
      if (fx[53:31] != {23{fx[31]}}) begin
         rsp_in.vertex_x = fx[53] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else begin
         rsp_in.vertex_x = fx[31:0];
      end
      if (fy[53:31] != {23{fy[31]}}) begin
         rsp_in.vertex_y = fy[53] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else begin
         rsp_in.vertex_y = fy[31:0];
      end
      rsp_in.vertex_z     = v3_meta_ff.vertex_z;
      rsp_in.vertex_color = v3_meta_ff.vertex_color;
      rsp_in.vertex_u     = v3_meta_ff.vertex_u;
      rsp_in.vertex_v     = v3_meta_ff.vertex_v;
      rsp_in.vertex_slot  = v3_meta_ff.vertex_slot;
      rsp_in.corner_index = v3_meta_ff.corner_index;
      rsp_in.last_vertex  = v3_meta_ff.last_vertex;
   end

   // Advance the vertex pipeline data
   always_ff @(posedge clock) begin
      if (ven) begin
         v1_meta_ff <= v1_meta_in;
         v1_ox_ff   <= v1_ox_in;
         v1_oy_ff   <= v1_oy_in;
         v1_sn_ff   <= exp_sn_ff;
         v1_cs_ff   <= exp_cs_ff;
         v2_meta_ff <= v1_meta_ff;
         p_cx_ff    <= p_cx_in;
         p_sy_ff    <= p_sy_in;
         p_sx_ff    <= p_sx_in;
         p_cy_ff    <= p_cy_in;
         v3_meta_ff <= v2_meta_ff;
         rx_ff      <= rx_in;
         ry_ff      <= ry_in;
         rsp_ff     <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_vld_ff  <= 1'b0;
         v2_vld_ff  <= 1'b0;
         v3_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else if (ven) begin
         v1_vld_ff  <= exp_vld_ff;
         v2_vld_ff  <= v1_vld_ff;
         v3_vld_ff  <= v2_vld_ff;
         rsp_vld_ff <= v3_vld_ff;
      end
   end

   assign rsp_chan.valid   = rsp_vld_ff;
   assign rsp_chan.payload = rsp_ff;

`ifndef SYNTH
   // Corner counter steps by one on each vertex transfer into the vertex pipeline
   a_corner_step: assert property (@(posedge clock) disable iff (reset)
      (exp_vld_ff && ven && exp_cnt_ff != 2'd3)
      |=> (exp_vld_ff && exp_cnt_ff == $past(exp_cnt_ff) + 2'd1))
      else $error("corner counter skipped or lost its sprite");

   // Request side only stalls behind a valid last sprite stage and a busy expander
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (exp_vld_ff && s_vld_ff[SLast]))
      else $error("request stalled without a held sprite");

   // No response straight after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_chan.valid)
      else $error("response valid after reset");
`endif

endmodule

`default_nettype wire
